// ----- sv/tli_pkg.sv -----
package tli_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   // Search gives up after this many probes and falls back to segment zero.
   localparam int MAX_PROBES = 20;
   localparam int PROBE_W    = $clog2(MAX_PROBES + 1);

   // Field widths.
   localparam int COORD_W  = 16;
   localparam int POINTS_W = 7;
   localparam int ENTRY_W  = 2 * COORD_W;

   localparam logic [POINTS_W-1:0] POINTS_RESET = 7'd33;

   // Operation codes.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Clamp kinds reported with each result.
   localparam logic [1:0] KIND_INTERP = 2'd0;
   localparam logic [1:0] KIND_BELOW  = 2'd1;
   localparam logic [1:0] KIND_ABOVE  = 2'd2;

   // Serial arithmetic unit sizing.
   localparam int PROD_W  = 2 * COORD_W;
   localparam int STEP_W  = $clog2(PROD_W);

endpackage

// ----- sv/tli_ram.sv -----
module tli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Single port: one address per cycle, written when enabled and always read into a register.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      read_data_ff <= mem_ff[address];
   end

   assign read_data = read_data_ff;

endmodule

// ----- sv/tli_muldiv.sv -----
module tli_muldiv
   import tli_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [COORD_W-1:0] multiplicand,
   input  logic [COORD_W-1:0] multiplier,
   input  logic [COORD_W-1:0] divisor,
   output logic               done,
   output logic [PROD_W-1:0]  quotient
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]         phase_ff, phase_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               done_ff, done_in;
   logic [COORD_W-1:0] mcand_ff, mcand_in;
   logic [COORD_W-1:0] dvsr_ff, dvsr_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [COORD_W:0]   rem_ff, rem_in;

   logic [COORD_W:0]   partial;
   logic [COORD_W:0]   shifted;
   logic [COORD_W+1:0] trial;

   // One multiplier bit per cycle: add the multiplicand into the upper half, shift right.
   assign partial = prod_ff[0]
      ? ({1'b0, prod_ff[PROD_W-1:COORD_W]} + {1'b0, mcand_ff})
      : {1'b0, prod_ff[PROD_W-1:COORD_W]};

   // One quotient bit per cycle: restoring division, dividend shifts out of the top.
   assign shifted = {rem_ff[COORD_W-1:0], prod_ff[PROD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvsr_ff};

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      mcand_in = mcand_ff;
      dvsr_in  = dvsr_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (go) begin
               mcand_in = multiplicand;
               dvsr_in  = divisor;
               prod_in  = {{COORD_W{1'b0}}, multiplier};
               step_in  = '0;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            prod_in = {partial, prod_ff[COORD_W-1:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(COORD_W - 1)) begin
               step_in  = '0;
               rem_in   = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            if (!trial[COORD_W+1]) begin
               rem_in  = trial[COORD_W:0];
               prod_in = {prod_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in  = shifted;
               prod_in = {prod_ff[PROD_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(PROD_W - 1)) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Control state is reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      step_ff  <= step_in;
      mcand_ff <= mcand_in;
      dvsr_ff  <= dvsr_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = prod_ff;

endmodule

// ----- sv/table_linear_interpolator_core.sv -----
// Piecewise-linear table interpolator for linearizing sensor readings.
// Input transactions enter on start while busy is low. A write transaction
// (req_opcode = write) stores req_point_x and req_point_y at req_point_index
// in the same cycle and produces no result; the block stays ready.
// A lookup transaction converts req_sample and produces exactly one result,
// shown on the rsp_ ports for one cycle while rsp_strobe is high.
// The receiver cannot stall; every strobed result must be captured.
// csr_write_enable writes csr_write_data into the point count register,
// which should only change while busy is low and no result is pending.
// A lookup first reads both table ends; a sample below the first x or
// above the last x is clamped and returns that end's y. Otherwise a binary
// search checks the upper, then if needed the lower, point of the middle
// segment, giving up after 20 steps and using segment zero. A vertical segment
// returns its upper y; any other goes through the serial arithmetic.
// The search is paced by the single-port table memory (one read per cycle,
// registered), and the arithmetic by a serial unit that forms the product
// and then the quotient, one bit each cycle.
// Lookups are taken one at a time; busy is high from accept until the
// result is strobed. Reset returns the sequencer to idle and the point
// count to 33; table contents are undefined until written.
module table_linear_interpolator_core
   import tli_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [5:0]          req_point_index,
   input  logic [15:0]         req_point_x,
   input  logic signed [15:0]  req_point_y,
   input  logic [15:0]         req_sample,
   input  logic                csr_write_enable,
   input  logic [6:0]          csr_write_data,
   output logic                rsp_strobe,
   output logic signed [15:0]  rsp_value,
   output logic [1:0]          rsp_clamp_kind,
   output logic [5:0]          rsp_segment
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RD_FIRST = 4'd1;
   localparam logic [3:0] S_RD_LAST  = 4'd2;
   localparam logic [3:0] S_PROBE    = 4'd3;
   localparam logic [3:0] S_CHK_HI   = 4'd4;
   localparam logic [3:0] S_CHK_LO   = 4'd5;
   localparam logic [3:0] S_LOAD_HI  = 4'd6;
   localparam logic [3:0] S_LOAD_LO  = 4'd7;
   localparam logic [3:0] S_SETUP    = 4'd8;
   localparam logic [3:0] S_ARITH    = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [POINTS_W-1:0] points_ff;
   logic [COORD_W-1:0]  sample_ff, sample_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    low_ff, low_in;
   logic [IDX_W-1:0]    high_ff, high_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [PROBE_W-1:0]  probes_ff, probes_in;
   logic [COORD_W-1:0]  x1_ff, x1_in, x2_ff, x2_in;
   logic [COORD_W-1:0]  y1_ff, y1_in, y2_ff, y2_in;
   logic                neg_ff, neg_in;
   logic                strobe_ff, strobe_in;
   logic [COORD_W-1:0]  value_ff, value_in;
   logic [1:0]          kind_ff, kind_in;
   logic [IDX_W-1:0]    segment_ff, segment_in;

   logic                accept;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_addr;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic [COORD_W-1:0]  rd_x, rd_y;
   logic [CNT_W-1:0]    count_clamped;
   logic [IDX_W-1:0]    last_idx, mid_limit, mid_raw, mid_probe;
   logic [COORD_W:0]    dx, dy;
   logic [COORD_W:0]    dx_mag, dy_mag;
   logic [COORD_W-1:0]  ds;
   logic                arith_go, arith_done;
   logic [PROD_W-1:0]   arith_quo;
   logic [PROD_W:0]     q_signed;
   logic [PROD_W+1:0]   total;
   logic [COORD_W-1:0]  total_sat;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Point count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= POINTS_RESET;
      end else if (csr_write_enable) begin
         points_ff <= csr_write_data;
      end
   end

   // Count of points in use, held to the legal range.
   always_comb begin
      if (points_ff < POINTS_W'(2)) begin
         count_clamped = CNT_W'(2);
      end else if (32'(points_ff) > TABLE_DEPTH) begin
         count_clamped = CNT_W'(TABLE_DEPTH);
      end else begin
         count_clamped = CNT_W'(points_ff);
      end
   end

   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign mid_limit = IDX_W'(count_ff - CNT_W'(2));
   assign mid_raw   = low_ff + ((high_ff - low_ff) >> 1);
   assign mid_probe = (mid_raw > mid_limit) ? mid_limit : mid_raw;

   assign rd_x = ram_rdata[ENTRY_W-1:COORD_W];
   assign rd_y = ram_rdata[COORD_W-1:0];

   // Breakpoint table: x in the upper half of each entry, y in the lower.
   tli_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock        (clock),
      .write_enable (ram_we),
      .address      (ram_addr),
      .write_data   ({req_point_x, req_point_y}),
      .read_data    (ram_rdata)
   );

   // Segment differences; the sample never lies below the lower end here.
   assign dx     = {1'b0, x2_ff} - {1'b0, x1_ff};
   assign dy     = {y2_ff[COORD_W-1], y2_ff} - {y1_ff[COORD_W-1], y1_ff};
   assign ds     = sample_ff - x1_ff;
   assign dx_mag = dx[COORD_W] ? (~dx + 1'b1) : dx;
   assign dy_mag = dy[COORD_W] ? (~dy + 1'b1) : dy;

   tli_muldiv u_muldiv (
      .clock        (clock),
      .reset        (reset),
      .go           (arith_go),
      .multiplicand (dy_mag[COORD_W-1:0]),
      .multiplier   (ds),
      .divisor      (dx_mag[COORD_W-1:0]),
      .done         (arith_done),
      .quotient     (arith_quo)
   );

   // Signed quotient, sum with the lower y, saturation to 16 bits.
   assign q_signed = neg_ff ? (~{1'b0, arith_quo} + 1'b1) : {1'b0, arith_quo};
   assign total    = {{(PROD_W + 2 - COORD_W){y1_ff[COORD_W-1]}}, y1_ff}
                   + {q_signed[PROD_W], q_signed};

   always_comb begin
      if (!total[PROD_W+1] && (total[PROD_W:COORD_W-1] != '0)) begin
         total_sat = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (total[PROD_W+1] && (total[PROD_W:COORD_W-1] != '1)) begin
         total_sat = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         total_sat = total[COORD_W-1:0];
      end
   end

   // Sequencer: table writes in idle; for lookups, end reads, binary search, then serial arithmetic.
   always_comb begin
      state_in   = state_ff;
      sample_in  = sample_ff;
      count_in   = count_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      mid_in     = mid_ff;
      probes_in  = probes_ff;
      x1_in      = x1_ff;
      y1_in      = y1_ff;
      x2_in      = x2_ff;
      y2_in      = y2_ff;
      neg_in     = neg_ff;
      strobe_in  = 1'b0;
      value_in   = value_ff;
      kind_in    = kind_ff;
      segment_in = segment_ff;
      ram_we     = 1'b0;
      ram_addr   = '0;
      arith_go   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            ram_addr = IDX_W'(req_point_index);
            if (accept) begin
               if (req_opcode == OP_WRITE) begin
                  ram_we = (32'(req_point_index) < TABLE_DEPTH);
               end else begin
                  ram_addr  = '0;
                  sample_in = req_sample;
                  count_in  = count_clamped;
                  state_in  = S_RD_FIRST;
               end
            end
         end
         S_RD_FIRST: begin
            x1_in    = rd_x;
            y1_in    = rd_y;
            ram_addr = last_idx;
            state_in = S_RD_LAST;
         end
         S_RD_LAST: begin
            if (sample_ff < x1_ff) begin
               value_in   = y1_ff;
               kind_in    = KIND_BELOW;
               segment_in = '0;
               strobe_in  = 1'b1;
               state_in   = S_IDLE;
            end else if (sample_ff > rd_x) begin
               value_in   = rd_y;
               kind_in    = KIND_ABOVE;
               segment_in = last_idx;
               strobe_in  = 1'b1;
               state_in   = S_IDLE;
            end else begin
               low_in    = '0;
               high_in   = last_idx;
               probes_in = '0;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            if ((low_ff <= high_ff) && (probes_ff < PROBE_W'(MAX_PROBES))) begin
               mid_in   = mid_probe;
               ram_addr = mid_probe + 1'b1;
               state_in = S_CHK_HI;
            end else begin
               // Search failed on a table that does not ascend: use segment zero.
               mid_in   = '0;
               ram_addr = IDX_W'(1);
               state_in = S_LOAD_HI;
            end
         end
         S_CHK_HI: begin
            if (sample_ff <= rd_x) begin
               x2_in    = rd_x;
               y2_in    = rd_y;
               ram_addr = mid_ff;
               state_in = S_CHK_LO;
            end else begin
               low_in    = mid_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               state_in  = S_PROBE;
            end
         end
         S_CHK_LO: begin
            if (sample_ff >= rd_x) begin
               x1_in    = rd_x;
               y1_in    = rd_y;
               state_in = S_SETUP;
            end else begin
               high_in   = mid_ff;
               probes_in = probes_ff + 1'b1;
               state_in  = S_PROBE;
            end
         end
         S_LOAD_HI: begin
            x2_in    = rd_x;
            y2_in    = rd_y;
            ram_addr = mid_ff;
            state_in = S_LOAD_LO;
         end
         S_LOAD_LO: begin
            x1_in    = rd_x;
            y1_in    = rd_y;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            segment_in = mid_ff;
            kind_in    = KIND_INTERP;
            if (x2_ff == x1_ff) begin
               // Vertical segment: take the upper y.
               value_in  = y2_ff;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               neg_in   = dx[COORD_W] ^ dy[COORD_W];
               arith_go = 1'b1;
               state_in = S_ARITH;
            end
         end
         S_ARITH: begin
            if (arith_done) begin
               value_in  = total_sat;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers take reset; search and result payload do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      sample_ff  <= sample_in;
      count_ff   <= count_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
      mid_ff     <= mid_in;
      probes_ff  <= probes_in;
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      x2_ff      <= x2_in;
      y2_ff      <= y2_in;
      neg_ff     <= neg_in;
      value_ff   <= value_in;
      kind_ff    <= kind_in;
      segment_ff <= segment_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_value      = value_ff;
   assign rsp_clamp_kind = kind_ff;
   assign rsp_segment    = 6'(segment_ff);

endmodule
